>>> sv/slfe_pkg.sv
// Shared types, constants and helpers for the serial loader frame engine.
package slfe_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int NAME_BUFFER  = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ARG_COUNT    = 5;

    localparam logic [7:0] NAME_MAX  = 8'(NAME_BUFFER - 1);
    localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_DEPTH);

    // input command codes
    localparam logic [1:0] CMD_SERIAL = 2'd0;
    localparam logic [1:0] CMD_ESCAPE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // frame command codes (first payload byte)
    localparam logic [7:0] FC_DETACH   = 8'd0;
    localparam logic [7:0] FC_WRITE    = 8'd1;
    localparam logic [7:0] FC_SET_CPU  = 8'd2;
    localparam logic [7:0] FC_SET_GFX  = 8'd3;
    localparam logic [7:0] FC_SET_PTR  = 8'd4;
    localparam logic [7:0] FC_KEY      = 8'd5;
    localparam logic [7:0] FC_SAVE_SET = 8'd6;
    localparam logic [7:0] FC_SAVE_REQ = 8'd7;

    typedef enum logic [1:0] {
        IC_BYTE,
        IC_ESCAPE,
        IC_READ,
        IC_TICK
    } item_class_t;

    typedef struct packed {
        item_class_t cls;
        logic [7:0]  data;
    } item_t;

    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_KEY,
        KIND_READ_REQ,
        KIND_SAVE_REQ,
        KIND_NAME,
        KIND_SUM_ERR,
        KIND_LINK_END,
        KIND_BUSY
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        space;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [15:0] save_size;
    } result_t;

    function automatic result_t make_result(kind_t k, logic sp, logic [15:0] a,
                                            logic [7:0] d, logic [15:0] s);
        result_t r;
        r.kind      = k;
        r.space     = sp;
        r.address   = a;
        r.data_byte = d;
        r.save_size = s;
        return r;
    endfunction

endpackage

>>> sv/serial_loader_frame_engine_unit.sv
// Serial loader frame engine: top level.
// Input channel (in_valid/in_stall) carries one item per handshake: a serial
// byte, an escape, a memory read response or a drain tick, selected by command.
// Output channel (out_valid/out_stall) carries result items: writes, keys,
// read and save requests, name bytes, checksum errors, link ends, busy drops;
// last marks the final result caused by one input item.
// Items enter a 4-entry queue; the engine takes a new item only when idle, so
// an item that yields two results keeps it busy until the second one is loaded,
// and a stalled output holds it too. The engine loop (fetch item and buffer
// read, then execute) and the registered payload buffer read set the pace. An
// item passes the queue and the item register; results leave by the output register.
// Reset: frame parser awaits a length byte, queue and output are empty, all
// addresses and save settings are zero; payload buffer contents are undefined.
// When the receiver stalls, the output register holds its item, the engine
// waits, and once the queue is full in_stall rises.
module serial_loader_frame_engine_unit import slfe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic        space,
    output logic [15:0] address,
    output logic [7:0]  data_byte,
    output logic [15:0] save_size,
    output logic        last
);

    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t out_res;

    slfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .rx_byte   (rx_byte),
        .read_data (read_data),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    slfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .out_last  (last)
    );

    assign kind      = out_res.kind;
    assign space     = out_res.space;
    assign address   = out_res.address;
    assign data_byte = out_res.data_byte;
    assign save_size = out_res.save_size;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("engine popped an empty queue");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("engine popped on consecutive cycles");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("second result of an item not presented at once");

    a_err_then_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SUM_ERR) |-> !last)
        else $error("checksum error not followed by link end");

endmodule

>>> sv/slfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/slfe_front.sv
// Front end: accepts input items, classifies them and queues them for the engine.
module slfe_front import slfe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_data,
    input  logic        q_pop,
    output logic        q_valid,
    output item_t       q_item
);

    item_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    item_t              new_item;

    always_comb
    begin
        case (command)
            CMD_SERIAL:
            begin
                new_item.cls  = IC_BYTE;
                new_item.data = rx_byte;
            end
            CMD_ESCAPE:
            begin
                new_item.cls  = IC_ESCAPE;
                new_item.data = 8'h00;
            end
            CMD_READ:
            begin
                new_item.cls  = IC_READ;
                new_item.data = read_data;
            end
            default:
            begin
                new_item.cls  = IC_TICK;
                new_item.data = 8'h00;
            end
        endcase
    end

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> sv/slfe_back.sv
// Back end: frame engine with payload buffer and result output register.
module slfe_back import slfe_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res,
    output logic    out_last
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_SUM,
        PH_DATA,
        PH_DRAIN,
        PH_NAME,
        PH_RDLO,
        PH_RDHI
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXEC,
        B_SECOND
    } bstate_t;

    bstate_t     bstate_reg, bstate_next;
    phase_t      phase_reg, phase_next;
    logic        rd_ok_reg, rd_ok_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  expected_sum_reg, expected_sum_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] write_address_reg, write_address_next;
    logic        write_space_reg, write_space_next;
    logic        address_valid_reg, address_valid_next;
    logic [15:0] save_address_reg, save_address_next;
    logic [15:0] save_size_reg, save_size_next;
    logic        escape_pending_reg, escape_pending_next;
    logic [7:0]  drain_index_reg, drain_index_next;
    logic [15:0] pointer_address_reg, pointer_address_next;
    logic [7:0]  pointer_low_reg, pointer_low_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_last_reg, out_last_next;

    item_t       item_reg;
    logic [7:0]  args_reg [ARG_COUNT];
    logic [7:0]  args_next [ARG_COUNT];
    result_t     out_res_reg, out_res_next;
    result_t     second_res_reg, second_res_next;

    logic [8:0]  rd_index;
    logic [7:0]  ram_rdata;
    logic [7:0]  rd_value;
    logic        ram_we;
    logic        store_wr;
    logic        out_free;
    logic        commit;
    logic        prim_valid;
    result_t     prim_res;
    logic        end_valid;
    result_t     end_res;
    logic [7:0]  cnt;
    logic [7:0]  sum;
    logic [7:0]  cmd;
    logic [7:0]  size;
    logic [7:0]  nlen;
    logic [7:0]  drain_inc;

    slfe_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_count_reg[BUF_AW-1:0]),
        .wdata (item_reg.data),
        .re    (q_pop),
        .raddr (rd_index[BUF_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_index = {1'b0, drain_index_reg} + ((phase_reg == PH_NAME) ? 9'd2 : 9'd1);
    assign rd_ok_next = (rd_index < BUF_LIMIT);
    assign rd_value = rd_ok_reg ? ram_rdata : 8'h00;
    assign q_pop    = (bstate_reg == B_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign end_res  = make_result(KIND_LINK_END, 1'b0, 16'h0000, 8'h00, 16'h0000);
    assign commit   = (bstate_reg == B_EXEC) && ((!prim_valid && !end_valid) || out_free);
    assign ram_we   = commit && store_wr;

    // engine step for the item in item_reg
    always_comb
    begin
        phase_next           = phase_reg;
        frame_length_next    = frame_length_reg;
        expected_sum_next    = expected_sum_reg;
        running_sum_next     = running_sum_reg;
        byte_count_next      = byte_count_reg;
        write_address_next   = write_address_reg;
        write_space_next     = write_space_reg;
        address_valid_next   = address_valid_reg;
        save_address_next    = save_address_reg;
        save_size_next       = save_size_reg;
        escape_pending_next  = escape_pending_reg;
        drain_index_next     = drain_index_reg;
        pointer_address_next = pointer_address_reg;
        pointer_low_next     = pointer_low_reg;
        prim_valid           = 1'b0;
        prim_res             = make_result(KIND_WRITE, 1'b0, 16'h0000, 8'h00, 16'h0000);
        end_valid            = 1'b0;
        store_wr             = 1'b0;
        cnt                  = byte_count_reg + 8'd1;
        sum                  = running_sum_reg + item_reg.data;
        drain_inc            = drain_index_reg + 8'd1;
        size                 = frame_length_reg - 8'd1;

        store_wr = (item_reg.cls == IC_BYTE) && (phase_reg == PH_DATA)
                   && ({1'b0, byte_count_reg} < BUF_LIMIT);
        for (int i = 0; i < ARG_COUNT; i++)
        begin
            args_next[i] = (store_wr && byte_count_reg == 8'(i)) ? item_reg.data : args_reg[i];
        end
        cmd  = args_next[0];
        nlen = (args_next[1] > NAME_MAX) ? NAME_MAX : args_next[1];

        case (item_reg.cls)
            IC_BYTE:
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        frame_length_next = item_reg.data;
                        phase_next        = PH_SUM;
                    end
                    PH_SUM:
                    begin
                        expected_sum_next = item_reg.data;
                        running_sum_next  = 8'h00;
                        byte_count_next   = 8'h00;
                        if (frame_length_reg == 8'h00)
                        begin
                            phase_next          = PH_LEN;
                            end_valid           = escape_pending_reg;
                            escape_pending_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        running_sum_next = sum;
                        byte_count_next  = cnt;
                        if (cnt == frame_length_reg)
                        begin
                            phase_next = PH_LEN;
                            if (sum != expected_sum_reg)
                            begin
                                prim_valid          = 1'b1;
                                prim_res            = make_result(KIND_SUM_ERR, 1'b0, 16'h0000,
                                                                  8'h00, 16'h0000);
                                end_valid           = 1'b1;
                                escape_pending_next = 1'b0;
                            end
                            else
                            begin
                                // frame done unless the command keeps the engine busy
                                end_valid           = escape_pending_reg;
                                escape_pending_next = 1'b0;
                                case (cmd)
                                    FC_DETACH:
                                    begin
                                        end_valid = 1'b1;
                                    end
                                    FC_WRITE:
                                    begin
                                        if (address_valid_reg && size != 8'h00)
                                        begin
                                            byte_count_next     = size;
                                            drain_index_next    = 8'h00;
                                            phase_next          = PH_DRAIN;
                                            end_valid           = 1'b0;
                                            escape_pending_next = escape_pending_reg;
                                        end
                                    end
                                    FC_SET_CPU, FC_SET_GFX:
                                    begin
                                        write_address_next = {args_next[2], args_next[1]};
                                        write_space_next   = (cmd == FC_SET_GFX);
                                        address_valid_next = 1'b1;
                                    end
                                    FC_SET_PTR:
                                    begin
                                        pointer_address_next = {args_next[2], args_next[1]};
                                        prim_valid           = 1'b1;
                                        prim_res             = make_result(KIND_READ_REQ, 1'b0,
                                                                   {args_next[2], args_next[1]},
                                                                   8'h00, 16'h0000);
                                        phase_next           = PH_RDLO;
                                        end_valid            = 1'b0;
                                        escape_pending_next  = escape_pending_reg;
                                    end
                                    FC_KEY:
                                    begin
                                        prim_valid = 1'b1;
                                        prim_res   = make_result(KIND_KEY, 1'b0, 16'h0000,
                                                                 args_next[1], 16'h0000);
                                    end
                                    FC_SAVE_SET:
                                    begin
                                        save_address_next = {args_next[2], args_next[1]};
                                        save_size_next    = {args_next[4], args_next[3]};
                                    end
                                    FC_SAVE_REQ:
                                    begin
                                        prim_valid = 1'b1;
                                        prim_res   = make_result(KIND_SAVE_REQ, 1'b0,
                                                                 save_address_reg, nlen,
                                                                 save_size_reg);
                                        if (nlen != 8'h00)
                                        begin
                                            byte_count_next     = nlen;
                                            drain_index_next    = 8'h00;
                                            phase_next          = PH_NAME;
                                            end_valid           = 1'b0;
                                            escape_pending_next = escape_pending_reg;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                        prim_valid = 1'b1;
                        prim_res   = make_result(KIND_BUSY, 1'b0, 16'h0000, 8'h00, 16'h0000);
                    end
                endcase
            end
            IC_ESCAPE:
            begin
                if (phase_reg == PH_LEN)
                begin
                    end_valid           = 1'b1;
                    escape_pending_next = 1'b0;
                end
                else
                begin
                    escape_pending_next = 1'b1;
                end
            end
            IC_READ:
            begin
                if (phase_reg == PH_RDLO)
                begin
                    pointer_low_next = item_reg.data;
                    prim_valid       = 1'b1;
                    prim_res         = make_result(KIND_READ_REQ, 1'b0,
                                                   pointer_address_reg + 16'd1,
                                                   8'h00, 16'h0000);
                    phase_next       = PH_RDHI;
                end
                else if (phase_reg == PH_RDHI)
                begin
                    write_address_next  = {item_reg.data, pointer_low_reg};
                    write_space_next    = 1'b0;
                    address_valid_next  = 1'b1;
                    phase_next          = PH_LEN;
                    end_valid           = escape_pending_reg;
                    escape_pending_next = 1'b0;
                end
            end
            default:
            begin
                if (phase_reg == PH_DRAIN || phase_reg == PH_NAME)
                begin
                    prim_valid       = 1'b1;
                    drain_index_next = drain_inc;
                    if (phase_reg == PH_DRAIN)
                    begin
                        prim_res           = make_result(KIND_WRITE, write_space_reg,
                                                         write_address_reg, rd_value, 16'h0000);
                        write_address_next = write_address_reg + 16'd1;
                    end
                    else
                    begin
                        prim_res = make_result(KIND_NAME, 1'b0, 16'h0000, rd_value, 16'h0000);
                    end
                    if (drain_inc == byte_count_reg)
                    begin
                        phase_next          = PH_LEN;
                        end_valid           = escape_pending_reg;
                        escape_pending_next = 1'b0;
                    end
                end
            end
        endcase
    end

    // sequencing and output register
    always_comb
    begin
        bstate_next     = bstate_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        second_res_next = second_res_reg;
        case (bstate_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    bstate_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (commit)
                begin
                    bstate_next = B_IDLE;
                    if (prim_valid || end_valid)
                    begin
                        out_valid_next  = 1'b1;
                        out_res_next    = prim_valid ? prim_res : end_res;
                        out_last_next   = !(prim_valid && end_valid);
                        second_res_next = end_res;
                        if (prim_valid && end_valid)
                        begin
                            bstate_next = B_SECOND;
                        end
                    end
                end
            end
            B_SECOND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = second_res_reg;
                    out_last_next  = 1'b1;
                    bstate_next    = B_IDLE;
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg          <= B_IDLE;
            out_valid_reg       <= 1'b0;
            out_last_reg        <= 1'b0;
            phase_reg           <= PH_LEN;
            frame_length_reg    <= 8'h00;
            expected_sum_reg    <= 8'h00;
            running_sum_reg     <= 8'h00;
            byte_count_reg      <= 8'h00;
            write_address_reg   <= 16'h0000;
            write_space_reg     <= 1'b0;
            address_valid_reg   <= 1'b0;
            save_address_reg    <= 16'h0000;
            save_size_reg       <= 16'h0000;
            escape_pending_reg  <= 1'b0;
            drain_index_reg     <= 8'h00;
            pointer_address_reg <= 16'h0000;
            pointer_low_reg     <= 8'h00;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (commit)
            begin
                phase_reg           <= phase_next;
                frame_length_reg    <= frame_length_next;
                expected_sum_reg    <= expected_sum_next;
                running_sum_reg     <= running_sum_next;
                byte_count_reg      <= byte_count_next;
                write_address_reg   <= write_address_next;
                write_space_reg     <= write_space_next;
                address_valid_reg   <= address_valid_next;
                save_address_reg    <= save_address_next;
                save_size_reg       <= save_size_next;
                escape_pending_reg  <= escape_pending_next;
                drain_index_reg     <= drain_index_next;
                pointer_address_reg <= pointer_address_next;
                pointer_low_reg     <= pointer_low_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg    <= out_res_next;
        second_res_reg <= second_res_next;
        if (q_pop)
        begin
            item_reg  <= q_item;
            rd_ok_reg <= rd_ok_next;
        end
        if (commit)
        begin
            for (int i = 0; i < ARG_COUNT; i++)
            begin
                args_reg[i] <= args_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for serial_loader_frame_engine_unit with random framed traffic.
module tb_top;
    import slfe_pkg::*;

    localparam int RANDOM_ITEMS = 1500;

    typedef logic [7:0] bytes_q_t[$];

    typedef enum logic [2:0] {
        LD_LEN,
        LD_SUM,
        LD_DATA,
        LD_DRAIN,
        LD_NAME,
        LD_RDLO,
        LD_RDHI
    } ld_phase_t;

    typedef enum logic [2:0] {
        SM_FREE,
        SM_LIGHT,
        SM_HEAVY,
        SM_TOGGLE,
        SM_HOLD
    } stall_mode_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } outcome_t;

    class loader_tracker;
        outcome_t    pending_results[$];
        outcome_t    step_results[$];
        logic [7:0]  store[BUFFER_DEPTH];
        ld_phase_t   ph;
        logic [7:0]  flen, esum, rsum, bcnt, didx, ptr_lo;
        logic [15:0] waddr, ptr_addr, save_addr, save_len;
        logic        wspace, avalid, esc;
        int          errors;
        int          useful;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            ph        = LD_LEN;
            flen      = 8'h00;
            esum      = 8'h00;
            rsum      = 8'h00;
            bcnt      = 8'h00;
            didx      = 8'h00;
            ptr_lo    = 8'h00;
            waddr     = 16'h0000;
            ptr_addr  = 16'h0000;
            save_addr = 16'h0000;
            save_len  = 16'h0000;
            wspace    = 1'b0;
            avalid    = 1'b0;
            esc       = 1'b0;
            errors    = 0;
            useful    = 0;
        endfunction

        function logic [7:0] peek(int i);
            return (i < BUFFER_DEPTH) ? store[i] : 8'h00;
        endfunction

        function void emit(kind_t k, logic sp, logic [15:0] a, logic [7:0] d,
                           logic [15:0] s);
            outcome_t o;
            o.res.kind      = k;
            o.res.space     = sp;
            o.res.address   = a;
            o.res.data_byte = d;
            o.res.save_size = s;
            o.last          = 1'b0;
            step_results.push_back(o);
        endfunction

        function void drop_link();
            emit(KIND_LINK_END, 1'b0, 16'h0000, 8'h00, 16'h0000);
            ph  = LD_LEN;
            esc = 1'b0;
        endfunction

        function void close_frame();
            ph = LD_LEN;
            if (esc)
                drop_link();
        endfunction

        function void run_frame_command();
            logic [7:0] fc, size, a0, a1, nlen;
            fc   = peek(0);
            size = flen - 8'd1;
            a0   = peek(1);
            a1   = peek(2);
            case (fc)
                FC_DETACH:
                begin
                    drop_link();
                    return;
                end
                FC_WRITE:
                begin
                    if (avalid && size != 8'd0)
                    begin
                        bcnt = size;
                        didx = 8'd0;
                        ph   = LD_DRAIN;
                        return;
                    end
                end
                FC_SET_CPU, FC_SET_GFX:
                begin
                    waddr  = {a1, a0};
                    wspace = (fc == FC_SET_GFX);
                    avalid = 1'b1;
                end
                FC_SET_PTR:
                begin
                    ptr_addr = {a1, a0};
                    emit(KIND_READ_REQ, 1'b0, ptr_addr, 8'h00, 16'h0000);
                    ph = LD_RDLO;
                    return;
                end
                FC_KEY:
                    emit(KIND_KEY, 1'b0, 16'h0000, a0, 16'h0000);
                FC_SAVE_SET:
                begin
                    save_addr = {a1, a0};
                    save_len  = {peek(4), peek(3)};
                end
                FC_SAVE_REQ:
                begin
                    nlen = (a0 > 8'(NAME_BUFFER - 1)) ? 8'(NAME_BUFFER - 1) : a0;
                    emit(KIND_SAVE_REQ, 1'b0, save_addr, nlen, save_len);
                    if (nlen != 8'd0)
                    begin
                        bcnt = nlen;
                        didx = 8'd0;
                        ph   = LD_NAME;
                        return;
                    end
                end
                default:
                    ;
            endcase
            close_frame();
        endfunction

        function void frame_byte(logic [7:0] b);
            case (ph)
                LD_LEN:
                begin
                    flen = b;
                    ph   = LD_SUM;
                end
                LD_SUM:
                begin
                    esum = b;
                    rsum = 8'h00;
                    bcnt = 8'h00;
                    if (flen == 8'd0)
                        close_frame();
                    else
                        ph = LD_DATA;
                end
                LD_DATA:
                begin
                    store[bcnt] = b;
                    rsum = rsum + b;
                    bcnt = bcnt + 8'd1;
                    if (bcnt == flen)
                    begin
                        if (rsum != esum)
                        begin
                            emit(KIND_SUM_ERR, 1'b0, 16'h0000, 8'h00, 16'h0000);
                            drop_link();
                        end
                        else
                            run_frame_command();
                    end
                end
                default:
                    emit(KIND_BUSY, 1'b0, 16'h0000, 8'h00, 16'h0000);
            endcase
        endfunction

        function void take_item(logic [1:0] c, logic [7:0] rb, logic [7:0] rd);
            bit ignored;
            ignored = 1'b0;
            step_results.delete();
            case (c)
                CMD_SERIAL:
                    frame_byte(rb);
                CMD_ESCAPE:
                begin
                    if (ph == LD_LEN)
                        drop_link();
                    else
                        esc = 1'b1;
                end
                CMD_READ:
                begin
                    if (ph == LD_RDLO)
                    begin
                        ptr_lo = rd;
                        emit(KIND_READ_REQ, 1'b0, ptr_addr + 16'd1, 8'h00, 16'h0000);
                        ph = LD_RDHI;
                    end
                    else if (ph == LD_RDHI)
                    begin
                        waddr  = {rd, ptr_lo};
                        wspace = 1'b0;
                        avalid = 1'b1;
                        close_frame();
                    end
                    else
                        ignored = 1'b1;
                end
                default:
                begin
                    if (ph == LD_DRAIN)
                    begin
                        emit(KIND_WRITE, wspace, waddr, peek(1 + didx), 16'h0000);
                        waddr = waddr + 16'd1;
                        didx  = didx + 8'd1;
                        if (didx == bcnt)
                            close_frame();
                    end
                    else if (ph == LD_NAME)
                    begin
                        emit(KIND_NAME, 1'b0, 16'h0000, peek(2 + didx), 16'h0000);
                        didx = didx + 8'd1;
                        if (didx == bcnt)
                            close_frame();
                    end
                    else
                        ignored = 1'b1;
                end
            endcase
            if (!ignored)
                useful++;
            foreach (step_results[i])
            begin
                outcome_t o;
                o      = step_results[i];
                o.last = (i == step_results.size() - 1);
                pending_results.push_back(o);
            end
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("MISMATCH %s", msg);
            errors++;
        endtask

        task check_result(logic [2:0] k, logic sp, logic [15:0] a, logic [7:0] d,
                          logic [15:0] s, logic l);
            outcome_t o;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected item kind %0d addr %h data %h", k, a, d));
                return;
            end
            o = pending_results.pop_front();
            if (k !== o.res.kind)
                report($sformatf("kind got %0d want %0d", k, o.res.kind));
            if (sp !== o.res.space)
                report($sformatf("space got %0d want %0d", sp, o.res.space));
            if (a !== o.res.address)
                report($sformatf("address got %h want %h", a, o.res.address));
            if (d !== o.res.data_byte)
                report($sformatf("data_byte got %h want %h", d, o.res.data_byte));
            if (s !== o.res.save_size)
                report($sformatf("save_size got %h want %h", s, o.res.save_size));
            if (l !== o.last)
                report($sformatf("last got %0d want %0d", l, o.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [7:0]  read_data;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic        space;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [15:0] save_size;
    logic        last;

    loader_tracker sb;
    int burst_left = 0;
    bit noise_on   = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    serial_loader_frame_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .rx_byte   (rx_byte),
        .read_data (read_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .space     (space),
        .address   (address),
        .data_byte (data_byte),
        .save_size (save_size),
        .last      (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, space, address, data_byte, save_size, last);
    end

    // receiver: stall segments of random style, one long hold-off when asked
    initial
    begin
        stall_mode_t mode;
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                mode      = SM_HOLD;
                n         = 400;
                hold_done = 1'b1;
            end
            else
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                n    = $urandom_range(10, 120);
            end
            repeat (n)
            begin
                @(negedge clk);
                case (mode)
                    SM_FREE:   out_stall <= 1'b0;
                    SM_LIGHT:  out_stall <= ($urandom_range(0, 9) < 2);
                    SM_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                    SM_TOGGLE: out_stall <= ~out_stall;
                    default:   out_stall <= 1'b1;
                endcase
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [1:0] c, input logic [7:0] rb,
                             input logic [7:0] rd);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid  <= 1'b1;
        command   <= c;
        rx_byte   <= rb;
        read_data <= rd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_item(c, rb, rd);
        @(negedge clk);
    endtask

    task automatic maybe_noise();
        logic [1:0] c;
        if (noise_on && $urandom_range(0, 99) < 3)
        begin
            case ($urandom_range(0, 2))
                0:       c = CMD_ESCAPE;
                1:       c = CMD_READ;
                default: c = CMD_TICK;
            endcase
            send_item(c, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic maybe_noise_forced();
        logic [1:0] c;
        case ($urandom_range(0, 2))
            0:       c = CMD_ESCAPE;
            1:       c = CMD_READ;
            default: c = CMD_TICK;
        endcase
        send_item(c, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_frame(input bytes_q_t pl, input bit bad_sum);
        logic [7:0] sum;
        sum = 8'h00;
        foreach (pl[i])
            sum = sum + pl[i];
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_item(CMD_SERIAL, 8'(pl.size()), 8'($urandom));
        maybe_noise();
        send_item(CMD_SERIAL, sum, 8'($urandom));
        foreach (pl[i])
        begin
            maybe_noise();
            send_item(CMD_SERIAL, pl[i], 8'($urandom));
        end
    endtask

    // drain ticks and read responses, with busy bytes and strays mixed in
    task automatic service_one();
        int r;
        logic [1:0] good;
        r    = $urandom_range(0, 99);
        good = (sb.ph == LD_RDLO || sb.ph == LD_RDHI) ? CMD_READ : CMD_TICK;
        if (r < 6)
            send_item(CMD_SERIAL, 8'($urandom), 8'($urandom));
        else if (r < 9)
            send_item(CMD_ESCAPE, 8'($urandom), 8'($urandom));
        else if (r < 12)
            send_item((good == CMD_READ) ? CMD_TICK : CMD_READ, 8'($urandom), 8'($urandom));
        else
            send_item(good, 8'($urandom), 8'($urandom));
    endtask

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bytes_q_t bytes_of(int n, logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2);
        bytes_q_t pl;
        pl.push_back(b0);
        if (n > 1)
            pl.push_back(b1);
        if (n > 2)
            pl.push_back(b2);
        return pl;
    endfunction

    function automatic bytes_q_t make_frame();
        bytes_q_t pl;
        int sel, n;
        logic [15:0] a;
        logic [7:0] nl;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            pl.push_back(FC_DETACH);
        else if (sel < 30)
        begin
            pl.push_back(FC_WRITE);
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 254) : $urandom_range(0, 10);
            repeat (n) pl.push_back(8'($urandom));
        end
        else if (sel < 52)
        begin
            if (sel < 44)
                pl.push_back($urandom_range(0, 1) ? FC_SET_GFX : FC_SET_CPU);
            else
                pl.push_back(FC_SET_PTR);
            a = pick_addr();
            pl.push_back(a[7:0]);
            pl.push_back(a[15:8]);
        end
        else if (sel < 60)
        begin
            pl.push_back(FC_KEY);
            pl.push_back(8'($urandom));
        end
        else if (sel < 68)
        begin
            pl.push_back(FC_SAVE_SET);
            a = pick_addr();
            pl.push_back(a[7:0]);
            pl.push_back(a[15:8]);
            a = pick_addr();
            pl.push_back(a[7:0]);
            pl.push_back(a[15:8]);
        end
        else if (sel < 82)
        begin
            nl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(31, 255))
                                              : 8'($urandom_range(0, 6));
            pl.push_back(FC_SAVE_REQ);
            pl.push_back(nl);
            repeat ($urandom_range(0, (nl > 31) ? 31 : nl)) pl.push_back(8'($urandom));
        end
        else
        begin
            pl.push_back(($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom_range(8, 255)));
            repeat ($urandom_range(0, 4)) pl.push_back(8'($urandom));
        end
        // payloads are sometimes trimmed, so short ones reuse older store contents, or padded
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            while (pl.size() > 1 && $urandom_range(0, 1))
                void'(pl.pop_back());
        end
        else if (sel == 1 && pl.size() < 250)
            repeat ($urandom_range(1, 5)) pl.push_back(8'($urandom));
        return pl;
    endfunction

    initial
    begin
        bytes_q_t pl;
        int r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_SERIAL;
        rx_byte   = 8'h00;
        read_data = 8'h00;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(CMD_ESCAPE, 8'h00, 8'hFF);
        send_item(CMD_SERIAL, 8'h00, 8'hFF);
        send_item(CMD_SERIAL, 8'hFF, 8'h00);
        send_frame(bytes_of(3, FC_WRITE, 8'hAA, 8'h55), 1'b0);
        send_frame(bytes_of(3, FC_SET_GFX, 8'hFF, 8'hFF), 1'b0);
        send_frame(bytes_of(3, FC_WRITE, 8'h00, 8'hFF), 1'b0);
        send_item(CMD_TICK, 8'hFF, 8'h00);
        send_item(CMD_SERIAL, 8'h55, 8'hAA);
        send_item(CMD_TICK, 8'h00, 8'hFF);
        send_frame(bytes_of(2, FC_KEY, 8'h80, 8'h00), 1'b1);

        noise_on = 1'b1;
        hold_req = 1'b1;
        // long name; also fills every store entry that later commands can read
        pl = bytes_of(2, FC_SAVE_REQ, 8'hFF, 8'h00);
        repeat (NAME_BUFFER - 1) pl.push_back(8'($urandom));
        send_frame(pl, 1'b0);

        while (sb.useful < RANDOM_ITEMS)
        begin
            case (sb.ph)
                LD_DRAIN, LD_NAME, LD_RDLO, LD_RDHI:
                    service_one();
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        send_item(CMD_SERIAL, 8'($urandom), 8'($urandom));
                    else if (r < 8)
                        maybe_noise_forced();
                    else if (r < 11)
                    begin
                        pl.delete();
                        send_frame(pl, 1'($urandom_range(0, 1)));
                    end
                    else
                        send_frame(make_frame(), $urandom_range(0, 19) == 0);
                end
            endcase
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report("items still expected at end");
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
